/* rtl/pdvm_pkg.sv */
// Shared types, constants and the sine table of the voice mixer.
package pdvm_pkg;

    localparam int VOICE_COUNT      = 32;
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int PHASE_BITS       = 24;

    localparam int SLOT_W  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int SIN_W   = $clog2(SINE_TABLE_DEPTH);
    localparam int GAIN_W  = 24;
    localparam int ENV_W   = 16;
    localparam int NOISE_W = 32;
    localparam int SAMP_W  = 16;
    localparam int VOL_W   = 7;
    localparam int SMAG_W  = 16;
    localparam int P1_W    = SMAG_W + GAIN_W;
    localparam int M_W     = P1_W + ENV_W - 30;
    localparam int ACC_W   = M_W + VOL_W + SLOT_W + 2;
    localparam int MAG_W   = ACC_W + VOL_W;
    localparam int REM_W   = MAG_W + 17;
    localparam int ADDR_W  = 4;
    localparam int DRAIN_CYC = 5;

    localparam logic [NOISE_W-1:0] LCG_MUL    = 32'd1664525;
    localparam logic [NOISE_W-1:0] LCG_ADD    = 32'd1013904223;
    localparam logic [NOISE_W-1:0] NOISE_SEED = 32'h9e3779b9;
    localparam logic [ENV_W-1:0]   ENV_STEP   = 16'd164;
    localparam logic [ENV_W-1:0]   ENV_ONE    = 16'd32768;
    localparam logic [GAIN_W-1:0]  GAIN_FLOOR = 24'd1678;
    localparam logic [REM_W-1:0]   MIX_UNIT   = REM_W'(64'd167772160000);
    localparam longint unsigned    HALF_PI_Q30 = 64'd1686629713;

    // register indexes
    localparam logic [1:0] REG_MASTER  = 2'd0;
    localparam logic [1:0] REG_MUSIC   = 2'd1;
    localparam logic [1:0] REG_EFFECTS = 2'd2;

    // waveform codes
    localparam logic [1:0] WAVE_SINE  = 2'd0;
    localparam logic [1:0] WAVE_PULSE = 2'd1;
    localparam logic [1:0] WAVE_TRI   = 2'd2;
    localparam logic [1:0] WAVE_NOISE = 2'd3;

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN, S_MIX} t_state;
    typedef enum logic [2:0] {D_IDLE, D_SCALE, D_LOAD, D_ITER, D_DONE} t_div_state;

    typedef struct packed {
        logic [PHASE_BITS-1:0] phase;
        logic [PHASE_BITS-1:0] step;
        logic [GAIN_W-1:0]     gain;
        logic [GAIN_W-1:0]     decay;
        logic [ENV_W-1:0]      env;
        logic [NOISE_W-1:0]    noise;
        logic [1:0]            wave;
        logic                  bus;
    } t_voice;

    typedef struct packed {
        logic        we;
        logic [23:0] step;
        logic [15:0] gain;
        logic [23:0] decay;
        logic [1:0]  wave;
        logic        bus;
    } t_start;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] slot;
    } t_walk;

    typedef struct packed {
        logic           valid;
        logic           neg;
        logic           bus;
        logic [M_W-1:0] mag;
    } t_term;

    typedef struct packed {
        logic [VOL_W-1:0] master;
        logic [VOL_W-1:0] music;
        logic [VOL_W-1:0] effects;
    } t_vol;

    typedef struct packed {
        logic signed [SAMP_W-1:0] sample;
        logic                     started;
        logic                     dropped;
    } t_rsp;

    typedef logic [15:0] t_sine_tab [SINE_TABLE_DEPTH+1];

    // quarter-wave table by a Taylor series in Q30
    function automatic t_sine_tab sine_table();
        t_sine_tab       tab;
        longint unsigned x, x2, term, sum, v, tp;
        int              r, n;
        for (r = 0; r <= SINE_TABLE_DEPTH; r++) begin
            x = (HALF_PI_Q30 * longint'(r)) / SINE_TABLE_DEPTH;
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            for (n = 1; n <= 7; n++) begin
                tp = (term * x2) >> 30;
                // divide by (2n)(2n+1)
                case (n)
                    1:       term = tp / 64'd6;
                    2:       term = tp / 64'd20;
                    3:       term = tp / 64'd42;
                    4:       term = tp / 64'd72;
                    5:       term = tp / 64'd110;
                    6:       term = tp / 64'd156;
                    default: term = tp / 64'd210;
                endcase
                if ((n & 1) == 1) sum = sum - term;
                else sum = sum + term;
            end
            v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
            tab[r] = (v > 64'd32767) ? 16'd32767 : v[15:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = sine_table();

endpackage

/* rtl/pdvm_chan_if.sv */
// Request and response channel interfaces of the voice mixer.
interface pdvm_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [23:0] phase_step;
    logic [15:0] start_gain;
    logic [23:0] decay_factor;
    logic [1:0]  waveform;
    logic        to_effects_bus;

    modport source (output valid, opcode, phase_step, start_gain, decay_factor,
                    waveform, to_effects_bus, input ready);
    modport sink   (input valid, opcode, phase_step, start_gain, decay_factor,
                    waveform, to_effects_bus, output ready);
endinterface

interface pdvm_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               voice_started;
    logic               voice_dropped;

    modport source (output valid, sample, voice_started, voice_dropped, input ready);
    modport sink   (input valid, sample, voice_started, voice_dropped, output ready);
endinterface

/* rtl/polyphonic_decay_voice_mixer.sv */
// Top level of the polyphonic decaying voice mixer: control, registers, output stage.
//
//  channel  | dir | request moves
//  ---------+-----+---------------------------------------------------
//  i_req    | in  | opcode, phase_step, start_gain, decay_factor, ...
//  o_rsp    | out | sample, voice_started, voice_dropped
//  APB      | in  | master/music/effects volume at 0x0, 0x4, 0x8
//
// A start request's response passes from the skid register to the output register
// and shows on o_rsp; i_req.ready returns in that same cycle.
// A tick walks all VOICE_COUNT slots through the voice memory one per cycle,
// drains the voice pipe, then scales the mix and divides it, and moves the result
// through the skid and output registers to o_rsp; i_req.ready returns in the cycle
// that the response shows.
// Reset clears the active flags at once; no memory clearing pass.
// A finished response waits in a skid register behind the output register;
// i_req.ready stays low while a response waits there.
module polyphonic_decay_voice_mixer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pdvm_req_if.sink                    i_req,
    pdvm_rsp_if.source                  o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pdvm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import pdvm_pkg::*;

    t_state r_state, n_state;

    logic [SLOT_W-1:0] r_slot;
    logic [2:0]        r_drain;
    t_vol              r_vol;
    t_rsp              r_pend, r_out;
    logic              r_pend_v, r_out_v;
    logic              accept, move, cfg_we;
    logic [1:0]        cfg_idx;
    t_start            start;
    t_walk             walk;
    t_term             term;
    logic              free;
    logic              mix_clear, mix_go, mix_done;
    logic signed [SAMP_W-1:0] mix_sample;

    assign i_req.ready = (r_state == S_IDLE) && !r_pend_v;
    assign accept = i_req.valid && i_req.ready;
    assign move   = r_pend_v && (!r_out_v || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept && !i_req.opcode) n_state = S_WALK;
            S_WALK:  if (r_slot == SLOT_W'(VOICE_COUNT - 1)) n_state = S_DRAIN;
            S_DRAIN: if (r_drain == 3'(DRAIN_CYC - 1)) n_state = S_MIX;
            S_MIX:   if (mix_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        walk.rd_en  = (r_state == S_WALK);
        walk.slot   = r_slot;
        mix_clear   = accept && !i_req.opcode;
        mix_go      = (r_state == S_DRAIN) && (r_drain == 3'(DRAIN_CYC - 1));
        start.we    = accept && i_req.opcode;
        start.step  = i_req.phase_step;
        start.gain  = i_req.start_gain;
        start.decay = i_req.decay_factor;
        start.wave  = i_req.waveform;
        start.bus   = i_req.to_effects_bus;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_WALK) r_slot <= r_slot + SLOT_W'(1);
            else r_slot <= '0;
            if (r_state == S_DRAIN) r_drain <= r_drain + 3'd1;
            else r_drain <= '0;
        end
    end

    pdvm_voice_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_walk  (walk),
        .o_free  (free),
        .o_term  (term)
    );

    pdvm_mix_div u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_term   (term),
        .i_vol    (r_vol),
        .i_clear  (mix_clear),
        .i_go     (mix_go),
        .o_done   (mix_done),
        .o_sample (mix_sample)
    );

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_comb begin
        unique case (cfg_idx)
            REG_MASTER:  prdata = 32'(r_vol.master);
            REG_MUSIC:   prdata = 32'(r_vol.music);
            REG_EFFECTS: prdata = 32'(r_vol.effects);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol.master  <= 7'd80;
            r_vol.music   <= 7'd80;
            r_vol.effects <= 7'd80;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_MASTER:  r_vol.master  <= pwdata[VOL_W-1:0];
                REG_MUSIC:   r_vol.music   <= pwdata[VOL_W-1:0];
                REG_EFFECTS: r_vol.effects <= pwdata[VOL_W-1:0];
                default: ;
            endcase
        end
    end

    // skid stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (move) r_pend_v <= 1'b0;
            if (start.we || mix_done) r_pend_v <= 1'b1;
            if (move) r_out_v <= 1'b1;
            else if (o_rsp.ready) r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start.we) begin
            r_pend.sample  <= '0;
            r_pend.started <= free;
            r_pend.dropped <= !free;
        end else if (mix_done) begin
            r_pend.sample  <= mix_sample;
            r_pend.started <= 1'b0;
            r_pend.dropped <= 1'b0;
        end
        if (move) r_out <= r_pend;
    end

    assign o_rsp.valid         = r_out_v;
    assign o_rsp.sample        = r_out.sample;
    assign o_rsp.voice_started = r_out.started;
    assign o_rsp.voice_dropped = r_out.dropped;

endmodule

/* rtl/pdvm_voice_engine.sv */
// Voice memory with read-modify-write oscillator, gain and envelope pipeline.
module pdvm_voice_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pdvm_pkg::t_start i_start,
    input  pdvm_pkg::t_walk  i_walk,
    output logic             o_free,
    output pdvm_pkg::t_term  o_term
);
    import pdvm_pkg::*;

    t_voice r_mem [VOICE_COUNT];
    t_voice r_rd;

    logic [VOICE_COUNT-1:0] r_active, n_active;
    logic                   r_b_v;
    logic [SLOT_W-1:0]      r_b_slot;
    logic [SLOT_W-1:0]      free_slot;
    t_voice                 st_rec;
    logic [47:0]            step_x;

    // stage B
    t_voice                  wb;
    logic [SIN_W+1:0]        sidx;
    logic [1:0]              quad;
    logic [SIN_W:0]          sr;
    logic [15:0]             smag;
    logic signed [17:0]      sin_v, tri_v, nz_v, s;
    logic [PHASE_BITS+6:0]   ph100;
    logic                    pulse_hi;
    logic [PHASE_BITS-1:0]   half, tri_dist;
    logic [PHASE_BITS+16:0]  dsh;
    logic [PHASE_BITS+16:0]  tq;
    logic [NOISE_W-1:0]      nn;
    logic [47:0]             gp;
    logic [GAIN_W-1:0]       gnew;
    logic [ENV_W:0]          es;
    logic [ENV_W-1:0]        enew;
    logic [SMAG_W-1:0]       sabs;

    // stages C, D, E
    logic              r_c_v, r_c_neg, r_c_bus;
    logic [SMAG_W-1:0] r_c_sabs;
    logic [GAIN_W-1:0] r_c_gain;
    logic [ENV_W-1:0]  r_c_env;
    logic              r_d_v, r_d_neg, r_d_bus;
    logic [P1_W-1:0]   r_d_p1;
    logic [ENV_W-1:0]  r_d_env;
    logic [P1_W+ENV_W-1:0] mp;
    logic              r_e_v, r_e_neg, r_e_bus;
    logic [M_W-1:0]    r_e_mag;

    // lowest free slot wins
    always_comb begin
        free_slot = '0;
        o_free = 1'b0;
        for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_slot = SLOT_W'(i);
                o_free = 1'b1;
            end
        end
    end

    always_comb begin
        step_x = {i_start.step, 24'b0} >> (48 - PHASE_BITS);
        st_rec.phase = '0;
        st_rec.step  = step_x[PHASE_BITS-1:0];
        st_rec.gain  = {i_start.gain, 8'b0};
        st_rec.decay = i_start.decay;
        st_rec.env   = '0;
        st_rec.noise = NOISE_SEED + NOISE_W'(free_slot);
        st_rec.wave  = i_start.wave;
        st_rec.bus   = i_start.bus;
    end

    always_comb begin
        sidx = r_rd.phase[PHASE_BITS-1 -: SIN_W+2];
        quad = sidx[SIN_W+1:SIN_W];
        sr   = {1'b0, sidx[SIN_W-1:0]};
        if (quad[0]) sr = (SIN_W+1)'(SINE_TABLE_DEPTH) - sr;
        smag = SINE_TAB[sr];
        sin_v = quad[1] ? -$signed({2'b0, smag}) : $signed({2'b0, smag});

        ph100 = (PHASE_BITS+7)'(r_rd.phase) * (PHASE_BITS+7)'(100);
        pulse_hi = ph100 < ((PHASE_BITS+7)'(35) << PHASE_BITS);

        half = PHASE_BITS'(1) << (PHASE_BITS - 1);
        tri_dist = (r_rd.phase >= half) ? r_rd.phase - half : half - r_rd.phase;
        dsh  = {tri_dist, 17'b0};
        tq   = dsh >> PHASE_BITS;
        tri_v = 18'sd32768 - $signed({1'b0, tq[16:0]});
        if (tri_v > 18'sd32767) tri_v = 18'sd32767;

        nn   = r_rd.noise * LCG_MUL + LCG_ADD;
        nz_v = $signed({2'b0, nn[31:16]}) - 18'sd32768;

        case (r_rd.wave)
            WAVE_SINE:  s = sin_v;
            WAVE_PULSE: s = pulse_hi ? 18'sd32767 : -18'sd32767;
            WAVE_TRI:   s = tri_v;
            default:    s = nz_v;
        endcase
        sabs = s[17] ? SMAG_W'(-s) : SMAG_W'(s);

        gp   = 48'(r_rd.gain) * 48'(r_rd.decay);
        gnew = gp[47:24];
        es   = {1'b0, r_rd.env} + {1'b0, ENV_STEP};
        enew = (es > {1'b0, ENV_ONE}) ? ENV_ONE : es[ENV_W-1:0];

        wb = r_rd;
        wb.phase = r_rd.phase + r_rd.step;
        wb.gain  = gnew;
        wb.env   = enew;
        if (r_rd.wave == WAVE_NOISE) wb.noise = nn;
    end

    always_comb begin
        n_active = r_active;
        if (i_start.we && o_free) n_active[free_slot] = 1'b1;
        if (r_b_v && (gnew < GAIN_FLOOR)) n_active[r_b_slot] = 1'b0;
    end

    // start writes only while no tick walk is in flight
    always_ff @(posedge i_clk) begin
        if (i_start.we && o_free) begin
            r_mem[free_slot] <= st_rec;
        end else if (r_b_v) begin
            r_mem[r_b_slot] <= wb;
        end
        r_rd <= r_mem[i_walk.slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_b_v    <= 1'b0;
            r_c_v    <= 1'b0;
            r_d_v    <= 1'b0;
            r_e_v    <= 1'b0;
        end else begin
            r_active <= n_active;
            r_b_v    <= i_walk.rd_en && r_active[i_walk.slot];
            r_c_v    <= r_b_v;
            r_d_v    <= r_c_v;
            r_e_v    <= r_d_v;
        end
    end

    assign mp = (P1_W+ENV_W)'(r_d_p1) * (P1_W+ENV_W)'(r_d_env);

    always_ff @(posedge i_clk) begin
        r_b_slot <= i_walk.slot;
        r_c_neg  <= s[17];
        r_c_bus  <= r_rd.bus;
        r_c_sabs <= sabs;
        r_c_gain <= gnew;
        r_c_env  <= enew;
        r_d_neg  <= r_c_neg;
        r_d_bus  <= r_c_bus;
        r_d_p1   <= P1_W'(r_c_sabs) * P1_W'(r_c_gain);
        r_d_env  <= r_c_env;
        r_e_neg  <= r_d_neg;
        r_e_bus  <= r_d_bus;
        r_e_mag  <= mp[P1_W+ENV_W-1:30];
    end

    always_comb begin
        o_term.valid = r_e_v;
        o_term.neg   = r_e_neg;
        o_term.bus   = r_e_bus;
        o_term.mag   = r_e_mag;
    end

endmodule

/* rtl/pdvm_mix_div.sv */
// Bus-weighted accumulator, master scaling and soft-clip divider.
module pdvm_mix_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pdvm_pkg::t_term                    i_term,
    input  pdvm_pkg::t_vol                     i_vol,
    input  logic                               i_clear,
    input  logic                               i_go,
    output logic                               o_done,
    output logic signed [pdvm_pkg::SAMP_W-1:0] o_sample
);
    import pdvm_pkg::*;

    t_div_state r_dst, n_dst;

    logic signed [ACC_W-1:0] r_acc, addend;
    logic [M_W+VOL_W-1:0]    tv;
    logic [VOL_W-1:0]        vol;
    logic [ACC_W-1:0]        aabs;
    logic [MAG_W-1:0]        r_mag;
    logic                    r_neg;
    logic [REM_W-1:0]        r_rem, r_den, den;
    logic [3:0]              r_cnt;
    logic [15:0]             r_q;
    logic                    ge;

    always_comb begin
        vol = i_term.bus ? i_vol.effects : i_vol.music;
        tv  = (M_W+VOL_W)'(i_term.mag) * (M_W+VOL_W)'(vol);
        addend = $signed(ACC_W'(tv));
        if (i_term.neg) addend = -addend;
        aabs = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        den  = MIX_UNIT + REM_W'(r_mag);
        ge   = r_rem >= r_den;
    end

    always_comb begin
        n_dst = r_dst;
        unique case (r_dst)
            D_IDLE:  if (i_go) n_dst = D_SCALE;
            D_SCALE: n_dst = D_LOAD;
            D_LOAD:  n_dst = D_ITER;
            D_ITER:  if (r_cnt == 4'd0) n_dst = D_DONE;
            D_DONE:  n_dst = D_IDLE;
            default: n_dst = D_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_dst == D_DONE);
        if (r_neg) o_sample = -$signed(r_q);
        else if (r_q > 16'd32767) o_sample = 16'sd32767;
        else o_sample = $signed(r_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst <= D_IDLE;
        end else begin
            r_dst <= n_dst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_acc <= '0;
        end else if (i_term.valid) begin
            r_acc <= r_acc + addend;
        end
        case (r_dst)
            D_SCALE: begin
                r_mag <= MAG_W'(aabs) * MAG_W'(i_vol.master);
                r_neg <= r_acc[ACC_W-1];
            end
            D_LOAD: begin
                // rounded quotient: (mag*32768 + den/2) / den, 16 bits
                r_rem <= (REM_W'(r_mag) << 15) + (den >> 1);
                r_den <= den << 15;
                r_cnt <= 4'd15;
                r_q   <= '0;
            end
            D_ITER: begin
                if (ge) r_rem <= r_rem - r_den;
                r_den <= r_den >> 1;
                r_q   <= {r_q[14:0], ge};
                r_cnt <= r_cnt - 4'd1;
            end
            default: ;
        endcase
    end

endmodule
